@@ design/chs_pkg.sv @@
package chs_pkg;

	localparam int HDR_BYTES = 8;
	localparam int CNT_W     = 3;

	typedef enum logic [1:0] {
		ST_FOUND       = 2'd0,
		ST_ZERO_SIZE   = 2'd1,
		ST_END_OF_DATA = 2'd2,
		ST_BAD_SIZE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_TARGET_ID       = 2'd0,
		REG_SIZE_MSB_FIRST  = 2'd1,
		REG_SIZE_INCL_HDR   = 2'd2,
		REG_BASE_OFFSET     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] target_id;
		logic        size_msb_first;
		logic        size_includes_header;
		logic [31:0] base_offset;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] chunk_data_offset;
		logic [31:0] chunk_length;
	} result_t;

	// reverse the byte order of a 32-bit word
	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

@@ design/chs_if.sv @@
interface chs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] chunk_data_offset;
	logic [31:0] chunk_length;

	modport source (output valid, output status, output chunk_data_offset,
		output chunk_length, input ready);
	modport sink   (input valid, input status, input chunk_data_offset,
		input chunk_length, output ready);
endinterface

interface chs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/chs_cfg_regs.sv @@
module chs_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [31:0]   wr_data,
	output chs_pkg::cfg_t cfg
);
	import chs_pkg::*;

	cfg_t cfg_q;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_TARGET_ID:      cfg_q.target_id <= wr_data;
				REG_SIZE_MSB_FIRST: cfg_q.size_msb_first <= wr_data[0];
				REG_SIZE_INCL_HDR:  cfg_q.size_includes_header <= wr_data[0];
				REG_BASE_OFFSET:    cfg_q.base_offset <= wr_data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

@@ design/chs_scan.sv @@
module chs_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  chs_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             res_free,
	output logic             res_load,
	output chs_pkg::result_t res
);
	import chs_pkg::*;

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// scan state
	logic [CNT_W-1:0] hdr_cnt_q;
	logic [55:0]      hdr_q;
	logic [31:0]      skip_q;
	logic [31:0]      pos_q;
	logic             done_q;

	logic             fire;
	logic [CNT_W-1:0] hdr_cnt_n;
	logic [55:0]      hdr_n;
	logic [31:0]      skip_n;
	logic [31:0]      pos_n;
	logic             done_n;
	logic [63:0]      hdr_full;
	logic [31:0]      size;
	logic             have;
	status_t          status;
	logic [31:0]      offs;
	logic [31:0]      len;

	assign fire     = valid_s1 && res_free;
	assign in_ready = !valid_s1 || fire;
	assign hdr_full = {hdr_q, byte_s1};
	assign size     = cfg.size_msb_first ? hdr_full[31:0] : swap32(hdr_full[31:0]);

	// process the registered word
	always_comb begin
		hdr_cnt_n = hdr_cnt_q;
		hdr_n     = hdr_q;
		skip_n    = skip_q;
		pos_n     = pos_q;
		done_n    = done_q;
		have      = 1'b0;
		status    = ST_FOUND;
		offs      = '0;
		len       = '0;
		if (!done_q) begin
			pos_n = pos_q + 32'd1;
			if (skip_q != '0) begin
				skip_n = skip_q - 32'd1;
			end else if (hdr_cnt_q != CNT_W'(HDR_BYTES - 1)) begin
				hdr_n     = hdr_full[55:0];
				hdr_cnt_n = hdr_cnt_q + CNT_W'(1);
			end else begin
				// header complete: decide on it
				hdr_n     = '0;
				hdr_cnt_n = '0;
				if (hdr_full[63:32] == cfg.target_id) begin
					have   = 1'b1;
					status = ST_FOUND;
					offs   = cfg.base_offset + pos_n;
					len    = size;
				end else if (size == '0) begin
					have   = 1'b1;
					status = ST_ZERO_SIZE;
				end else if (cfg.size_includes_header) begin
					if (size < 32'(HDR_BYTES)) begin
						have   = 1'b1;
						status = ST_BAD_SIZE;
					end else begin
						skip_n = size - 32'(HDR_BYTES);
					end
				end else begin
					skip_n = size;
				end
			end
			if (!have && last_s1) begin
				have   = 1'b1;
				status = ST_END_OF_DATA;
			end
			if (have) begin
				done_n = 1'b1;
			end
		end
		// re-arm on the last word of a file
		if (last_s1) begin
			hdr_cnt_n = '0;
			hdr_n     = '0;
			skip_n    = '0;
			pos_n     = '0;
			done_n    = 1'b0;
		end
	end

	// hold the input word until it is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// advance scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			skip_q    <= '0;
			pos_q     <= '0;
			done_q    <= 1'b0;
		end else if (fire) begin
			hdr_cnt_q <= hdr_cnt_n;
			skip_q    <= skip_n;
			pos_q     <= pos_n;
			done_q    <= done_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hdr_q <= hdr_n;
		end
	end

	assign res_load              = fire && have;
	assign res.status            = status;
	assign res.chunk_data_offset = offs;
	assign res.chunk_length      = len;
endmodule

@@ design/chs_out_reg.sv @@
module chs_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  chs_pkg::result_t res,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output chs_pkg::result_t out_res
);
	import chs_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || out_ready;

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
endmodule

@@ design/chunk_header_scanner_top.sv @@
// A word accepted into the input register is decided there; a result it yields is
// loaded into the output register once it is free and held until the sink takes it.
// Throughput: one word per cycle; the input register stalls only while a
// finished result waits in the output register and the sink holds ready low.
// Configuration writes are always ready.
// Reset (arst_n low, asynchronous): state registers cleared, scan armed at a header.
module chunk_header_scanner_top (
	input logic       clk,
	input logic       arst_n,
	chs_in_if.sink    byte_in,
	chs_out_if.source result_out,
	chs_cfg_if.sink   cfg
);
	import chs_pkg::*;

	cfg_t    cfg_val;
	result_t res;
	result_t out_res;
	logic    res_load;
	logic    res_free;

	assign cfg.ready = 1'b1;

	chs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	chs_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_val),
		.in_valid (byte_in.valid),
		.in_ready (byte_in.ready),
		.in_byte  (byte_in.data_byte),
		.in_last  (byte_in.last_byte),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res)
	);

	chs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res       (res),
		.free      (res_free),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.out_res   (out_res)
	);

	assign result_out.status            = out_res.status;
	assign result_out.chunk_data_offset = out_res.chunk_data_offset;
	assign result_out.chunk_length      = out_res.chunk_length;
endmodule

@@ design/chs_checker.sv @@
module chs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_status,
	input logic [31:0] out_offset,
	input logic [31:0] out_length
);
	import chs_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status)
		&& $stable(out_offset) && $stable(out_length))
		else $error("result changed while stalled");

	// only a found result carries offset and length
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_FOUND |-> out_offset == '0 && out_length == '0)
		else $error("non-found result with nonzero fields");

	// a new result must trace back to an earlier accepted input word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input word");

	// input stalls only under output backpressure
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");
endmodule

bind chunk_header_scanner_top chs_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (byte_in.valid),
	.in_ready   (byte_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.out_status (result_out.status),
	.out_offset (result_out.chunk_data_offset),
	.out_length (result_out.chunk_length)
);

@@ test/testbench.sv @@
module testbench;
	import chs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 4;     // margin after the last expected result is out
	localparam int RANDOM_BYTES = 500;   // bytes sent in the random part
	localparam int MAX_REPORTS  = 60;

	// one line of the directed table: a register write or a run of up to 8 bytes
	typedef enum logic {ROW_BYTES, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    reg_idx;
		logic [3:0]  count;
		logic [63:0] bytes;     // first byte most significant, right-aligned
		logic        last;      // last flag on the final byte of the row
		logic        given;     // result of the final byte typed in below
		status_t     status;
		logic [31:0] offs;
		logic [31:0] len;
	} dir_row_t;

	localparam int DIR_ROWS = 14;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// reset settings: target 0, little-endian size, header not counted
		'{ROW_BYTES, REG_TARGET_ID, 4'd1, 64'hFF, 1'b1,
			1'b1, ST_END_OF_DATA, 32'h0, 32'h0},
		'{ROW_BYTES, REG_TARGET_ID, 4'd8, 64'h6A756E6B_00000000, 1'b0,
			1'b1, ST_ZERO_SIZE, 32'h0, 32'h0},
		'{ROW_BYTES, REG_TARGET_ID, 4'd1, 64'h00, 1'b1,
			1'b0, ST_FOUND, 32'h0, 32'h0},
		'{ROW_BYTES, REG_TARGET_ID, 4'd8, 64'h00000000_FF000080, 1'b1,
			1'b1, ST_FOUND, 32'h8, 32'h800000FF},
		// big-endian, header-inclusive, offset that wraps
		'{ROW_REG, REG_TARGET_ID, 4'd0, 64'h64617461, 1'b0,
			1'b0, ST_FOUND, 32'h0, 32'h0},
		'{ROW_REG, REG_SIZE_MSB_FIRST, 4'd0, 64'h1, 1'b0,
			1'b0, ST_FOUND, 32'h0, 32'h0},
		'{ROW_REG, REG_SIZE_INCL_HDR, 4'd0, 64'h1, 1'b0,
			1'b0, ST_FOUND, 32'h0, 32'h0},
		'{ROW_REG, REG_BASE_OFFSET, 4'd0, 64'hFFFFFFF8, 1'b0,
			1'b0, ST_FOUND, 32'h0, 32'h0},
		'{ROW_BYTES, REG_TARGET_ID, 4'd8, 64'h4C495354_00000008, 1'b0,
			1'b0, ST_FOUND, 32'h0, 32'h0},
		'{ROW_BYTES, REG_TARGET_ID, 4'd8, 64'h64617461_00000010, 1'b0,
			1'b1, ST_FOUND, 32'h8, 32'h10},
		'{ROW_BYTES, REG_TARGET_ID, 4'd1, 64'h55, 1'b1,
			1'b0, ST_FOUND, 32'h0, 32'h0},
		'{ROW_REG, REG_TARGET_ID, 4'd0, 64'hFFFFFFFF, 1'b0,
			1'b0, ST_FOUND, 32'h0, 32'h0},
		'{ROW_BYTES, REG_TARGET_ID, 4'd8, 64'h666D7420_00000004, 1'b1,
			1'b1, ST_BAD_SIZE, 32'h0, 32'h0},
		'{ROW_BYTES, REG_TARGET_ID, 4'd8, 64'h6A756E6B_00000010, 1'b1,
			1'b1, ST_END_OF_DATA, 32'h0, 32'h0}
	};

	logic clk = 1'b0;
	logic arst_n;

	chs_in_if  byte_if ();
	chs_out_if res_if ();
	chs_cfg_if cfg_if ();

	chunk_header_scanner_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_if),
		.result_out (res_if),
		.cfg        (cfg_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scanner copy: settings
	logic [31:0] scan_target;
	logic        scan_big;
	logic        scan_incl;
	logic [31:0] scan_start;

	// scanner copy: progress through the current file
	logic [3:0]  hdr_cnt;
	logic [63:0] hdr_bytes;
	logic [31:0] skip_left;
	logic [31:0] byte_pos;
	logic        scan_done;

	result_t expected_results [$];

	int fail_count    = 0;
	int report_count  = 0;
	int scanned_bytes = 0;
	int sent_bytes    = 0;
	int result_count  = 0;
	int file_count    = 0;
	int setting_count = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int burst_left    = 0;
	bit cfg_busy      = 1'b0;

	function automatic void rearm_scan();
		hdr_cnt   = '0;
		hdr_bytes = '0;
		skip_left = '0;
		byte_pos  = '0;
		scan_done = 1'b0;
	endfunction

	// advance the scan by one byte; return 1 when it yields a result
	function automatic bit scan_byte(input logic [7:0] b, input logic last,
		output result_t res);
		logic [31:0] id;
		logic [31:0] raw;
		logic [31:0] blk_size;
		bit hit;

		hit = 1'b0;
		res = '0;
		if (scan_done) begin
			if (last)
				rearm_scan();
			return 1'b0;
		end
		byte_pos = byte_pos + 32'd1;

		// skip chunk data, else gather the header
		if (skip_left != 0) begin
			skip_left = skip_left - 32'd1;
		end else begin
			hdr_bytes = {hdr_bytes[55:0], b};
			hdr_cnt   = hdr_cnt + 4'd1;
			if (hdr_cnt >= 4'd8) begin
				id  = hdr_bytes[63:32];
				raw = hdr_bytes[31:0];
				blk_size = scan_big ? raw
					: {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
				hdr_cnt   = '0;
				hdr_bytes = '0;
				if (id == scan_target) begin
					hit = 1'b1;
					res.status = ST_FOUND;
					res.chunk_data_offset = scan_start + byte_pos;
					res.chunk_length = blk_size;
				end else if (blk_size == 0) begin
					hit = 1'b1;
					res.status = ST_ZERO_SIZE;
				end else if (scan_incl) begin
					if (blk_size < 32'd8) begin
						hit = 1'b1;
						res.status = ST_BAD_SIZE;
					end else begin
						skip_left = blk_size - 32'd8;
					end
				end else begin
					skip_left = blk_size;
				end
			end
		end

		if (!hit && last) begin
			hit = 1'b1;
			res.status = ST_END_OF_DATA;
		end
		if (hit) begin
			if (last)
				rearm_scan();
			else
				scan_done = 1'b1;
		end
		return hit;
	endfunction

	// hold the stream and wait until every pending result is out
	task automatic drain();
		byte_if.valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write one register; valid stays up so writes can follow back to back
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		cfg_busy = 1'b1;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		case (idx)
			REG_TARGET_ID:      scan_target = value;
			REG_SIZE_MSB_FIRST: scan_big    = value[0];
			REG_SIZE_INCL_HDR:  scan_incl   = value[0];
			REG_BASE_OFFSET:    scan_start  = value;
			default: ;
		endcase
	endtask

	// send one word, then record what it should yield
	task automatic send_byte(input logic [7:0] b, input logic last,
		input bit given_valid, input result_t given);
		result_t pred;
		bit was_scanning;

		if (cfg_busy) begin
			cfg_if.valid <= 1'b0;
			cfg_busy = 1'b0;
		end
		if (burst_left == 0) begin
			byte_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		byte_if.valid     <= 1'b1;
		byte_if.data_byte <= b;
		byte_if.last_byte <= last;
		do
			@(posedge clk);
		while (!byte_if.ready);

		was_scanning = !scan_done;
		if (scan_byte(b, last, pred) && !given_valid)
			expected_results.push_back(pred);
		if (given_valid)
			expected_results.push_back(given);
		if (was_scanning)
			scanned_bytes++;
		sent_bytes++;
		burst_left--;
	endtask

	// receiver stalls follow a 16-bit pattern, reshuffled each round
	logic [15:0] stall_pat = '1;
	logic [3:0]  stall_pos = '0;

	always @(posedge clk) begin
		if (stall_pos == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = '1;
				1: stall_pat = $urandom;
				default: stall_pat = $urandom | $urandom;
			endcase
		end
		res_if.ready <= stall_pat[stall_pos];
		stall_pos = stall_pos + 4'd1;
	end

	// compare each word on the result channel with the oldest expectation
	always @(posedge clk) begin
		result_t exp_res;

		if (arst_n && res_if.valid && res_if.ready) begin
			result_count++;
			status_seen[res_if.status]++;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (report_count++ < MAX_REPORTS)
					$display("%0t: expected no result, got status %0d offs %h len %h",
						$time, res_if.status, res_if.chunk_data_offset,
						res_if.chunk_length);
			end else begin
				exp_res = expected_results.pop_front();
				if (exp_res.status !== res_if.status) begin
					fail_count++;
					if (report_count++ < MAX_REPORTS)
						$display("%0t: status: expected %s, got %0d",
							$time, exp_res.status.name(), res_if.status);
				end
				if (exp_res.chunk_data_offset !== res_if.chunk_data_offset) begin
					fail_count++;
					if (report_count++ < MAX_REPORTS)
						$display("%0t: chunk_data_offset: expected %h, got %h",
							$time, exp_res.chunk_data_offset,
							res_if.chunk_data_offset);
				end
				if (exp_res.chunk_length !== res_if.chunk_length) begin
					fail_count++;
					if (report_count++ < MAX_REPORTS)
						$display("%0t: chunk_length: expected %h, got %h",
							$time, exp_res.chunk_length, res_if.chunk_length);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		dir_row_t row;
		logic [7:0] file_q [$];
		logic [31:0] id;
		logic [31:0] blk_size;
		int phase;
		int phase_end;
		int rand_end;
		int nchunks;
		int kind;
		int n;
		int cut;
		bit truncated;

		// hold everything quiet through reset
		arst_n            = 1'b0;
		byte_if.valid     = 1'b0;
		byte_if.data_byte = '0;
		byte_if.last_byte = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = REG_TARGET_ID;
		cfg_if.data       = '0;
		scan_target = '0;
		scan_big    = 1'b0;
		scan_incl   = 1'b0;
		scan_start  = '0;
		rearm_scan();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = DIR_TABLE[r];
			if (row.kind == ROW_REG) begin
				if (!cfg_busy) begin
					drain();
					setting_count++;
				end
				write_reg(row.reg_idx, row.bytes[31:0]);
			end else begin
				for (int k = 0; k < row.count; k++)
					send_byte(row.bytes[8 * (row.count - 1 - k) +: 8],
						row.last && k == row.count - 1,
						row.given && k == row.count - 1,
						result_t'({row.status, row.offs, row.len}));
				if (row.last)
					file_count++;
			end
		end

		// random part: one register setting per phase, whole files within it
		phase = 0;
		phase_end = sent_bytes;
		rand_end = sent_bytes + RANDOM_BYTES;
		while (sent_bytes < rand_end) begin
			drain();
			setting_count++;
			case ($urandom_range(0, 3))
				0: write_reg(REG_TARGET_ID, 32'h0);
				1: write_reg(REG_TARGET_ID, 32'hFFFFFFFF);
				2: write_reg(REG_TARGET_ID, 32'h64617461);
				default: write_reg(REG_TARGET_ID, $urandom);
			endcase
			write_reg(REG_SIZE_MSB_FIRST, (phase < 4) ? phase[0] : $urandom_range(0, 1));
			write_reg(REG_SIZE_INCL_HDR, (phase < 4) ? phase[1] : $urandom_range(0, 1));
			case (phase % 4)
				0: write_reg(REG_BASE_OFFSET, 32'hFFFFFFFF);
				1: write_reg(REG_BASE_OFFSET, 32'h0);
				2: write_reg(REG_BASE_OFFSET, 32'hFFFFFF00 | $urandom_range(0, 255));
				default: write_reg(REG_BASE_OFFSET, $urandom);
			endcase
			phase_end = sent_bytes + $urandom_range(60, 140);

			while (sent_bytes < phase_end) begin
				file_q.delete();
				if ($urandom_range(0, 9) < 7) begin
					// well-formed chunks with random content, some cut short
					nchunks = $urandom_range(1, 4);
					truncated = 1'b0;
					for (int c = 0; c < nchunks && !truncated; c++) begin
						id = ($urandom_range(0, 9) < 4) ? scan_target : $urandom;
						kind = $urandom_range(0, 99);
						n = 0;
						if (kind < 8) begin
							blk_size = 0;
						end else if (kind < 16 && scan_incl) begin
							blk_size = $urandom_range(1, 7);
						end else if (kind < 20) begin
							blk_size = $urandom | 32'h100;
							n = $urandom_range(0, 5);
							truncated = 1'b1;
						end else begin
							n = $urandom_range(0, 10);
							blk_size = scan_incl ? n + 8 : n;
						end
						for (int k = 3; k >= 0; k--)
							file_q.push_back(id[8 * k +: 8]);
						for (int k = 3; k >= 0; k--)
							file_q.push_back(scan_big ? blk_size[8 * k +: 8]
								: blk_size[8 * (3 - k) +: 8]);
						repeat (n) file_q.push_back($urandom_range(0, 255));
					end
					if (!truncated && $urandom_range(0, 4) == 0) begin
						cut = $urandom_range(1, file_q.size());
						while (file_q.size() > cut)
							void'(file_q.pop_back());
					end
					repeat ($urandom_range(0, 2)) file_q.push_back($urandom_range(0, 255));
				end else begin
					// noise
					repeat ($urandom_range(1, 24)) file_q.push_back($urandom_range(0, 255));
				end
				foreach (file_q[i])
					send_byte(file_q[i], i == file_q.size() - 1, 1'b0, '0);
				file_count++;
			end
			phase++;
		end

		// let the last results come out
		drain();

		$display("Sent %0d bytes (%0d scanned) in %0d files under %0d register settings",
			sent_bytes, scanned_bytes, file_count, setting_count);
		$display("Checked %0d results: %0d found, %0d zero-size, %0d end, %0d bad-size",
			result_count, status_seen[ST_FOUND], status_seen[ST_ZERO_SIZE],
			status_seen[ST_END_OF_DATA], status_seen[ST_BAD_SIZE]);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
